>>> rtl/core/direct_mapped_byte_cache_assert.svh
// ----------------------------------------------------------------------------
// direct_mapped_byte_cache assertion macros
// immediate-consequence and next-cycle property forms on clk, reset rst_n
// ----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_BYTE_CACHE_ASSERT_SVH
`define DIRECT_MAPPED_BYTE_CACHE_ASSERT_SVH

// consequence holds in the same cycle as the antecedent
`define DMBC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dmbc assertion failed");

// consequence holds in the cycle after the antecedent
`define DMBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dmbc assertion failed");

`endif

>>> rtl/core/dmbc_pkg.sv
// ----------------------------------------------------------------------------
// dmbc_pkg
// shared sizes, codes and address helpers of the direct-mapped byte cache
// ----------------------------------------------------------------------------
package dmbc_pkg;

  localparam int LINE_COUNT     = 8;
  localparam int BYTES_PER_LINE = 16;
  localparam int MEMORY_BYTES   = 4096;

  localparam int ADDR_W     = 12;
  localparam int DATA_W     = 8;
  localparam int TAG_OUT_W  = 8;
  localparam int CNT_W      = 32;
  localparam int PENALTY_W  = 8;

  localparam int WORD_W         = $clog2(BYTES_PER_LINE);
  localparam int LINE_W         = $clog2(LINE_COUNT);
  localparam int MEM_ADDR_W     = $clog2(MEMORY_BYTES);
  localparam int LINE_MEM_DEPTH = LINE_COUNT * BYTES_PER_LINE;
  localparam int LINE_ADDR_W    = LINE_W + WORD_W;
  localparam int FILL_CNT_W     = WORD_W + 1;

  localparam logic [TAG_OUT_W-1:0] EMPTY_TAG     = 8'hFF;
  localparam logic [DATA_W-1:0]    FILL_BYTE     = 8'h23;
  localparam logic [PENALTY_W-1:0] PENALTY_RESET = 8'd20;
  localparam logic [CNT_W-1:0]     CNT_MAX       = '1;

  // apb register map
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_MISS_PENALTY = 1'b0;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // operands for the shared saturating adder
  typedef struct packed {
    logic [CNT_W-1:0] a;
    logic [CNT_W-1:0] b;
  } add_req_t;

  function automatic logic [MEM_ADDR_W-1:0] mem_index(input logic [ADDR_W-1:0] addr);
    return MEM_ADDR_W'(addr);
  endfunction

  function automatic logic [WORD_W-1:0] word_of(input logic [MEM_ADDR_W-1:0] idx);
    return idx[WORD_W-1:0];
  endfunction

  function automatic logic [LINE_W-1:0] line_of(input logic [MEM_ADDR_W-1:0] idx);
    return idx[WORD_W +: LINE_W];
  endfunction

  function automatic logic [TAG_OUT_W-1:0] tag_of(input logic [MEM_ADDR_W-1:0] idx);
    return TAG_OUT_W'(idx >> (WORD_W + LINE_W));
  endfunction

endpackage

>>> rtl/core/direct_mapped_byte_cache.sv
// ----------------------------------------------------------------------------
// direct_mapped_byte_cache
// direct-mapped read cache of byte lines in front of a backing byte memory
// ----------------------------------------------------------------------------
// A load transaction (opcode 0) writes one backing byte in its accept cycle and
// the block is ready again in the next cycle; it returns nothing. A read
// transaction returns one result: a hit goes through accept, then tag compare
// and line data read; a miss adds the refill that walks the single read port
// of the backing memory one byte per cycle, followed by one shared saturating
// adder step each for the miss count and the elapsed time. in_stall is high
// while a read is in work. A finished result waits in the output register,
// and a new transaction is accepted meanwhile. Line data needs no clearing
// after reset: an empty tag marks the line and never matches, so its data is
// only read after a refill.
// miss_penalty sits at byte address 0 of the apb port.
module direct_mapped_byte_cache (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_opcode,
  input  logic [dmbc_pkg::ADDR_W-1:0]         in_address,
  input  logic [dmbc_pkg::DATA_W-1:0]         in_write_byte,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_hit,
  output logic [dmbc_pkg::DATA_W-1:0]         out_read_byte,
  output logic [dmbc_pkg::TAG_OUT_W-1:0]      out_old_tag,
  output logic [dmbc_pkg::CNT_W-1:0]          out_misses_so_far,
  output logic [dmbc_pkg::CNT_W-1:0]          out_time_so_far,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dmbc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [dmbc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [dmbc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_FILL,
    S_CNT_MISS,
    S_CNT_TIME,
    S_RESULT
  } state_t;

  state_t                                state_r, state_nxt;
  logic [dmbc_pkg::MEM_ADDR_W-1:0]       idx_r, idx_nxt;
  logic [dmbc_pkg::FILL_CNT_W-1:0]       fill_cnt_r, fill_cnt_nxt;
  logic [dmbc_pkg::TAG_OUT_W-1:0]        tags_r   [dmbc_pkg::LINE_COUNT];
  logic [dmbc_pkg::TAG_OUT_W-1:0]        tags_nxt [dmbc_pkg::LINE_COUNT];
  logic [dmbc_pkg::CNT_W-1:0]            miss_total_r, miss_total_nxt;
  logic [dmbc_pkg::CNT_W-1:0]            elapsed_total_r, elapsed_total_nxt;
  logic [dmbc_pkg::PENALTY_W-1:0]        penalty_r, penalty_nxt;
  logic                                  hit_r, hit_nxt;
  logic [dmbc_pkg::DATA_W-1:0]           byte_r, byte_nxt;
  logic [dmbc_pkg::TAG_OUT_W-1:0]        prev_tag_r, prev_tag_nxt;
  logic                                  out_valid_r, out_valid_nxt;
  logic                                  out_hit_r, out_hit_nxt;
  logic [dmbc_pkg::DATA_W-1:0]           out_byte_r, out_byte_nxt;
  logic [dmbc_pkg::TAG_OUT_W-1:0]        out_old_tag_r, out_old_tag_nxt;
  logic [dmbc_pkg::CNT_W-1:0]            out_misses_r, out_misses_nxt;
  logic [dmbc_pkg::CNT_W-1:0]            out_time_r, out_time_nxt;

  logic                                  accept;
  logic                                  out_free;
  logic [dmbc_pkg::MEM_ADDR_W-1:0]       idx_in;
  logic [dmbc_pkg::LINE_W-1:0]           line_cur;
  logic [dmbc_pkg::WORD_W-1:0]           word_cur;
  logic [dmbc_pkg::TAG_OUT_W-1:0]        tag_cur;
  logic [dmbc_pkg::TAG_OUT_W-1:0]        prev_tag;
  logic                                  lookup_hit;
  logic [dmbc_pkg::WORD_W-1:0]           fill_wr_idx;
  logic                                  cfg_write;
  logic [dmbc_pkg::REG_IDX_W-1:0]        cfg_idx;

  dmbc_pkg::add_req_t                    add_req;
  logic [dmbc_pkg::CNT_W-1:0]            add_sum;

  logic                                  back_we;
  logic [dmbc_pkg::MEM_ADDR_W-1:0]       back_raddr;
  logic [dmbc_pkg::DATA_W-1:0]           back_q;
  logic                                  line_we;
  logic [dmbc_pkg::LINE_ADDR_W-1:0]      line_waddr;
  logic [dmbc_pkg::LINE_ADDR_W-1:0]      line_raddr;
  logic [dmbc_pkg::DATA_W-1:0]           line_q;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign idx_in    = dmbc_pkg::mem_index(in_address);

  assign line_cur   = dmbc_pkg::line_of(idx_r);
  assign word_cur   = dmbc_pkg::word_of(idx_r);
  assign tag_cur    = dmbc_pkg::tag_of(idx_r);
  assign prev_tag   = tags_r[line_cur];
  assign lookup_hit = (prev_tag == tag_cur);

  // refill writes land in the cycle after their backing reads
  assign fill_wr_idx = dmbc_pkg::WORD_W'(fill_cnt_r - dmbc_pkg::FILL_CNT_W'(1));

  assign back_we    = accept && (in_opcode == dmbc_pkg::OP_LOAD);
  assign back_raddr = {idx_r[dmbc_pkg::MEM_ADDR_W-1:dmbc_pkg::WORD_W],
                       fill_cnt_r[dmbc_pkg::WORD_W-1:0]};

  assign line_we    = (state_r == S_FILL) && (fill_cnt_r != '0);
  assign line_waddr = {line_cur, fill_wr_idx};
  assign line_raddr = {dmbc_pkg::line_of(idx_in), dmbc_pkg::word_of(idx_in)};

  assign cfg_idx   = paddr[dmbc_pkg::CFG_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign prdata    = (cfg_idx == dmbc_pkg::REG_MISS_PENALTY) ?
                     dmbc_pkg::CFG_DATA_W'(penalty_r) : '0;

  dmbc_ram #(
    .WIDTH (dmbc_pkg::DATA_W),
    .DEPTH (dmbc_pkg::MEMORY_BYTES)
  ) u_back_ram (
    .clk   (clk),
    .we    (back_we),
    .waddr (idx_in),
    .wdata (in_write_byte),
    .raddr (back_raddr),
    .rdata (back_q)
  );

  dmbc_ram #(
    .WIDTH (dmbc_pkg::DATA_W),
    .DEPTH (dmbc_pkg::LINE_MEM_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (back_q),
    .raddr (line_raddr),
    .rdata (line_q)
  );

  dmbc_sat_add u_sat_add (
    .req (add_req),
    .sum (add_sum)
  );

  // operand select for the shared adder
  always_comb begin
    unique case (state_r)
      S_CNT_MISS: begin
        add_req.a = miss_total_r;
        add_req.b = dmbc_pkg::CNT_W'(1);
      end
      S_CNT_TIME: begin
        add_req.a = elapsed_total_r;
        add_req.b = dmbc_pkg::CNT_W'(penalty_r);
      end
      default: begin
        add_req.a = elapsed_total_r;
        add_req.b = dmbc_pkg::CNT_W'(1);
      end
    endcase
  end

  always_comb begin
    state_nxt         = state_r;
    idx_nxt           = idx_r;
    fill_cnt_nxt      = fill_cnt_r;
    tags_nxt          = tags_r;
    miss_total_nxt    = miss_total_r;
    elapsed_total_nxt = elapsed_total_r;
    penalty_nxt       = penalty_r;
    hit_nxt           = hit_r;
    byte_nxt          = byte_r;
    prev_tag_nxt      = prev_tag_r;
    out_valid_nxt     = out_valid_r;
    out_hit_nxt       = out_hit_r;
    out_byte_nxt      = out_byte_r;
    out_old_tag_nxt   = out_old_tag_r;
    out_misses_nxt    = out_misses_r;
    out_time_nxt      = out_time_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_write && (cfg_idx == dmbc_pkg::REG_MISS_PENALTY)) begin
      penalty_nxt = pwdata[dmbc_pkg::PENALTY_W-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_opcode == dmbc_pkg::OP_READ)) begin
          idx_nxt   = idx_in;
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        prev_tag_nxt = prev_tag;
        hit_nxt      = lookup_hit;
        if (lookup_hit) begin
          // a matching tag is never empty, so the line was refilled before
          byte_nxt          = line_q;
          elapsed_total_nxt = add_sum;
          if (out_free) begin
            out_valid_nxt   = 1'b1;
            out_hit_nxt     = 1'b1;
            out_byte_nxt    = line_q;
            out_old_tag_nxt = prev_tag;
            out_misses_nxt  = miss_total_r;
            out_time_nxt    = add_sum;
            state_nxt       = S_IDLE;
          end else begin
            state_nxt = S_RESULT;
          end
        end else begin
          fill_cnt_nxt = '0;
          state_nxt    = S_FILL;
        end
      end
      S_FILL: begin
        fill_cnt_nxt = fill_cnt_r + dmbc_pkg::FILL_CNT_W'(1);
        if ((fill_cnt_r != '0) && (fill_wr_idx == word_cur)) begin
          byte_nxt = back_q;
        end
        if (fill_cnt_r == dmbc_pkg::FILL_CNT_W'(dmbc_pkg::BYTES_PER_LINE)) begin
          tags_nxt[line_cur] = tag_cur;
          state_nxt          = S_CNT_MISS;
        end
      end
      S_CNT_MISS: begin
        miss_total_nxt = add_sum;
        state_nxt      = S_CNT_TIME;
      end
      S_CNT_TIME: begin
        elapsed_total_nxt = add_sum;
        state_nxt         = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_hit_nxt     = hit_r;
          out_byte_nxt    = byte_r;
          out_old_tag_nxt = prev_tag_r;
          out_misses_nxt  = miss_total_r;
          out_time_nxt    = elapsed_total_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      fill_cnt_r      <= '0;
      miss_total_r    <= '0;
      elapsed_total_r <= '0;
      penalty_r       <= dmbc_pkg::PENALTY_RESET;
      out_valid_r     <= 1'b0;
      for (int i = 0; i < dmbc_pkg::LINE_COUNT; i++) begin
        tags_r[i] <= dmbc_pkg::EMPTY_TAG;
      end
    end else begin
      state_r         <= state_nxt;
      fill_cnt_r      <= fill_cnt_nxt;
      miss_total_r    <= miss_total_nxt;
      elapsed_total_r <= elapsed_total_nxt;
      penalty_r       <= penalty_nxt;
      out_valid_r     <= out_valid_nxt;
      tags_r          <= tags_nxt;
    end
    idx_r         <= idx_nxt;
    hit_r         <= hit_nxt;
    byte_r        <= byte_nxt;
    prev_tag_r    <= prev_tag_nxt;
    out_hit_r     <= out_hit_nxt;
    out_byte_r    <= out_byte_nxt;
    out_old_tag_r <= out_old_tag_nxt;
    out_misses_r  <= out_misses_nxt;
    out_time_r    <= out_time_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_read_byte     = out_byte_r;
  assign out_old_tag       = out_old_tag_r;
  assign out_misses_so_far = out_misses_r;
  assign out_time_so_far   = out_time_r;

endmodule

>>> rtl/core/dmbc_ram.sv
// ----------------------------------------------------------------------------
// dmbc_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module dmbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/dmbc_sat_add.sv
// ----------------------------------------------------------------------------
// dmbc_sat_add
// shared 32-bit adder that clamps at all ones on carry out
// ----------------------------------------------------------------------------
module dmbc_sat_add (
  input  dmbc_pkg::add_req_t           req,
  output logic [dmbc_pkg::CNT_W-1:0]   sum
);

  logic [dmbc_pkg::CNT_W:0] raw;

  assign raw = {1'b0, req.a} + {1'b0, req.b};
  assign sum = raw[dmbc_pkg::CNT_W] ? dmbc_pkg::CNT_MAX : raw[dmbc_pkg::CNT_W-1:0];

endmodule

>>> rtl/core/dmbc_checker.sv
// ----------------------------------------------------------------------------
// dmbc_checker
// port-level checks of the direct-mapped byte cache, bound to the top level
// ----------------------------------------------------------------------------
`include "direct_mapped_byte_cache_assert.svh"

module dmbc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              in_opcode,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_hit,
  input logic [dmbc_pkg::TAG_OUT_W-1:0]    out_old_tag,
  input logic [dmbc_pkg::CNT_W-1:0]        out_misses_so_far
);

  // a stalled result stays offered
  `DMBC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // a read transaction keeps the block busy in the next cycle
  `DMBC_ASSERT_NEXT(a_read_busy, in_valid && !in_stall && (in_opcode == dmbc_pkg::OP_READ), in_stall)

  // a load transaction finishes in its accept cycle
  `DMBC_ASSERT_NEXT(a_load_free, in_valid && !in_stall && (in_opcode == dmbc_pkg::OP_LOAD), !in_stall)

  // a hit can only come from a line that holds a tag
  `DMBC_ASSERT_SAME(a_hit_tag, out_valid && out_hit, out_old_tag != dmbc_pkg::EMPTY_TAG)

  // a miss result always carries a nonzero miss count
  `DMBC_ASSERT_SAME(a_miss_cnt, out_valid && !out_hit, out_misses_so_far != '0)

endmodule

bind direct_mapped_byte_cache dmbc_checker u_dmbc_checker (.*);

>>> tb/sv/direct_mapped_byte_cache_tb.sv
// ----------------------------------------------------------------------------
// direct_mapped_byte_cache_tb
// drives loads and reads through the cache with random idling on both sides,
// predicts every read result from a private copy of the tags, lines, backing
// bytes and counters, and compares each result field by field
// ----------------------------------------------------------------------------
module direct_mapped_byte_cache_tb;
  import dmbc_pkg::*;

  localparam int IDLE_PCT      = 19;
  localparam int DRAIN_CYCLES  = 40;
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASE_ITEMS   = 315;
  localparam int POOL_BLOCKS   = 12;
  localparam int BLOCK_COUNT   = MEMORY_BYTES / BYTES_PER_LINE;
  localparam logic [CFG_ADDR_W-1:0] PENALTY_ADDR = {REG_MISS_PENALTY, 2'b00};

  typedef struct packed {
    logic                 hit;
    logic [DATA_W-1:0]    read_byte;
    logic [TAG_OUT_W-1:0] old_tag;
    logic [CNT_W-1:0]     misses_so_far;
    logic [CNT_W-1:0]     time_so_far;
  } read_result_t;

  class cache_scoreboard;
    logic [DATA_W-1:0]    backing [MEMORY_BYTES];
    bit                   loaded [MEMORY_BYTES];
    logic [TAG_OUT_W-1:0] tags [LINE_COUNT];
    logic [DATA_W-1:0]    lines [LINE_COUNT*BYTES_PER_LINE];
    logic [CNT_W-1:0]     miss_total;
    logic [CNT_W-1:0]     elapsed_total;
    logic [PENALTY_W-1:0] penalty;
    read_result_t         pending_reads [$];
    int unsigned          mismatches;

    function new();
      foreach (tags[i]) tags[i] = EMPTY_TAG;
      foreach (lines[i]) lines[i] = FILL_BYTE;
      foreach (loaded[i]) loaded[i] = 1'b0;
      miss_total    = '0;
      elapsed_total = '0;
      penalty       = PENALTY_RESET;
      mismatches    = 0;
    endfunction

    function logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a, input logic [CNT_W-1:0] b);
      logic [CNT_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    endfunction

    function bit will_hit(input logic [ADDR_W-1:0] addr);
      int idx;
      idx = int'(addr) % MEMORY_BYTES;
      return tags[(idx / BYTES_PER_LINE) % LINE_COUNT] ==
             TAG_OUT_W'(idx / (BYTES_PER_LINE * LINE_COUNT));
    endfunction

    function void note_access(input op_t op, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
      int idx;
      int word;
      int line;
      int base;
      logic [TAG_OUT_W-1:0] tag;
      read_result_t r;
      idx = int'(addr) % MEMORY_BYTES;
      if (op == OP_LOAD) begin
        // loads touch only the backing memory, cached copies go stale
        backing[idx] = data;
        loaded[idx]  = 1'b1;
        return;
      end
      word = idx % BYTES_PER_LINE;
      line = (idx / BYTES_PER_LINE) % LINE_COUNT;
      tag  = TAG_OUT_W'(idx / (BYTES_PER_LINE * LINE_COUNT));
      r.old_tag = tags[line];
      r.hit     = (tags[line] == tag);
      if (r.hit) begin
        elapsed_total = sat_add(elapsed_total, CNT_W'(1));
      end else begin
        base = idx - word;
        for (int i = 0; i < BYTES_PER_LINE; i++)
          lines[line*BYTES_PER_LINE + i] = backing[(base + i) % MEMORY_BYTES];
        tags[line]    = tag;
        miss_total    = sat_add(miss_total, CNT_W'(1));
        elapsed_total = sat_add(elapsed_total, CNT_W'(penalty));
      end
      r.read_byte     = lines[line*BYTES_PER_LINE + word];
      r.misses_so_far = miss_total;
      r.time_so_far   = elapsed_total;
      pending_reads.push_back(r);
    endfunction

    function void compare(input string field, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%s mismatch: expected %0h, got %0h", field, want, got);
      end
    endfunction

    function void check_result(input read_result_t got);
      read_result_t want;
      if (pending_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("read result with no transaction pending: %p", got);
        return;
      end
      want = pending_reads.pop_front();
      compare("hit", 64'(want.hit), 64'(got.hit));
      compare("read_byte", 64'(want.read_byte), 64'(got.read_byte));
      compare("old_tag", 64'(want.old_tag), 64'(got.old_tag));
      compare("misses_so_far", 64'(want.misses_so_far), 64'(got.misses_so_far));
      compare("time_so_far", 64'(want.time_so_far), 64'(got.time_so_far));
    endfunction

    function void check_leftover();
      if (pending_reads.size() != 0) begin
        mismatches += pending_reads.size();
        $display("%0d read results never arrived", pending_reads.size());
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_opcode = OP_LOAD;
  logic [ADDR_W-1:0]     in_address = '0;
  logic [DATA_W-1:0]     in_write_byte = '0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_hit;
  logic [DATA_W-1:0]     out_read_byte;
  logic [TAG_OUT_W-1:0]  out_old_tag;
  logic [CNT_W-1:0]      out_misses_so_far;
  logic [CNT_W-1:0]      out_time_so_far;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  cache_scoreboard sb = new();
  bit              quiet = 1'b0;
  int              items_sent = 0;
  int              idle_cycles = 0;

  direct_mapped_byte_cache u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_address        (in_address),
    .in_write_byte     (in_write_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_read_byte     (out_read_byte),
    .out_old_tag       (out_old_tag),
    .out_misses_so_far (out_misses_so_far),
    .out_time_so_far   (out_time_so_far),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{hit: out_hit, read_byte: out_read_byte, old_tag: out_old_tag,
                        misses_so_far: out_misses_so_far, time_so_far: out_time_so_far});
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input op_t op, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] data);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_address    <= addr;
    in_write_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_access(op, addr, data);
    items_sent++;
  endtask

  // a miss refills the whole line, so every byte of it gets loaded first
  task automatic read_through(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] base;
    base = addr & ~ADDR_W'(BYTES_PER_LINE - 1);
    if (!sb.will_hit(addr)) begin
      for (int i = 0; i < BYTES_PER_LINE; i++)
        if (!sb.loaded[int'(base) + i])
          send_item(OP_LOAD, base + ADDR_W'(i), DATA_W'($urandom_range(0, 255)));
    end
    send_item(OP_READ, addr, DATA_W'($urandom_range(0, 255)));
  endtask

  task automatic reg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_penalty(input logic [PENALTY_W-1:0] value);
    logic [CFG_DATA_W-1:0] rd;
    drain();
    reg_access(1'b1, PENALTY_ADDR, CFG_DATA_W'(value), rd);
    sb.penalty = value;
    reg_access(1'b0, PENALTY_ADDR, '0, rd);
    sb.compare("miss_penalty readback", 64'(value), 64'(rd));
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] rd;
    logic [PENALTY_W-1:0]  penalties [5];
    int unsigned           pool [POOL_BLOCKS];
    int                    phase_end;
    int                    pick;
    logic [ADDR_W-1:0]     addr;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    reg_access(1'b0, PENALTY_ADDR, '0, rd);
    sb.compare("miss_penalty after reset", 64'(PENALTY_RESET), 64'(rd));

    // directed: cold miss, hits at both word ends, stale copy after a load,
    // conflict on line 0, top of memory and data extremes
    read_through(12'h000);
    send_item(OP_READ, 12'h000, 8'h00);
    send_item(OP_READ, 12'h00F, 8'hFF);
    send_item(OP_LOAD, 12'h005, 8'hFF);
    send_item(OP_READ, 12'h005, 8'h00);
    send_item(OP_LOAD, 12'hFFF, 8'h00);
    read_through(12'h800);
    read_through(12'h005);
    read_through(12'hFFF);
    send_item(OP_READ, 12'hFF0, 8'hA5);
    send_item(OP_LOAD, 12'h7F5, 8'h5A);
    read_through(12'h7F5);

    penalties = '{8'd255, 8'd0, PENALTY_W'($urandom_range(2, 254)), 8'd20, 8'd1};
    for (int phase = 0; phase < 5; phase++) begin
      set_penalty(penalties[phase]);
      quiet = (phase == 2);
      foreach (pool[i]) pool[i] = $urandom_range(0, BLOCK_COUNT - 1);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        addr = ADDR_W'(pool[$urandom_range(0, POOL_BLOCKS - 1)] * BYTES_PER_LINE
                       + $urandom_range(0, BYTES_PER_LINE - 1));
        if (pick < 70)
          read_through(addr);
        else if (pick < 90)
          send_item(OP_LOAD, addr, DATA_W'($urandom_range(0, 255)));
        else
          send_item(OP_LOAD, ADDR_W'($urandom_range(0, MEMORY_BYTES - 1)),
                    DATA_W'($urandom_range(0, 255)));
      end
    end
    quiet = 1'b0;

    drain();
    sb.check_leftover();
    if (sb.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
